### rtl/core/cdu_pkg.sv
// Shared types, constants and arithmetic helpers for the calendar date unit.
package cdu_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DELTA_W = 16;
	localparam int CENT_W  = 7;
	localparam int DOY_W   = 9;
	localparam int WEEK_W  = 6;
	localparam int TOTAL_W = 19;

	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_MAX  = 4'd12;
	localparam logic signed [TOTAL_W-1:0] MOVE_MIN = 19'sd12;
	localparam logic signed [TOTAL_W-1:0] MOVE_LIM = 19'sd120000;

	// Reciprocal constants for division by small constants
	localparam logic [12:0] RECIP100 = 13'd5243;   // 2^19 / 100, rounded up
	localparam logic [15:0] RECIP3   = 16'd43691;  // 2^17 / 3, rounded up
	localparam logic [15:0] RECIP7W  = 16'd37450;  // 2^18 / 7, rounded up
	localparam logic [11:0] RECIP7N  = 12'd2341;   // 2^14 / 7, rounded up

	localparam logic WEEK_ISO    = 1'b0;
	localparam logic WEEK_SIMPLE = 1'b1;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [YEAR_W-1:0]  year_prev;
		logic [CENT_W-1:0]  cent;
		logic [CENT_W-1:0]  cent_prev;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [TOTAL_W-1:0] total;
	} norm_t;

	typedef struct packed {
		logic [DOY_W-1:0]  day_of_year;
		logic [WEEK_W-1:0] week_number;
		logic [2:0]        quarter;
		logic              leap_year;
		logic [DAY_W-1:0]  month_length;
		logic [2:0]        weekday;
	} info_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  moved_year;
		logic [MONTH_W-1:0] moved_month;
		logic [DAY_W-1:0]   moved_day;
		logic               move_out_of_range;
	} move_t;

	// Floor of y / 100 for y up to 9999
	function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] y);
		logic [26:0] prod;
		prod = 27'(y) * 27'(RECIP100);
		return prod[25:19];
	endfunction

	// Gregorian leap test given y and floor(y / 100)
	function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [CENT_W-1:0] q);
		logic [YEAR_W-1:0] hund;
		logic              even_cent;
		hund      = 14'(q) * 14'd100;
		even_cent = (y == hund);
		return ((y[1:0] == 2'd0) && !even_cent) || (even_cent && (q[1:0] == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] d;
		case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	function automatic logic [2:0] dow_offset(input logic [MONTH_W-1:0] m);
		logic [2:0] o;
		case (m)
			4'd2:    o = 3'd3;
			4'd3:    o = 3'd2;
			4'd4:    o = 3'd5;
			4'd5:    o = 3'd0;
			4'd6:    o = 3'd3;
			4'd7:    o = 3'd5;
			4'd8:    o = 3'd1;
			4'd9:    o = 3'd4;
			4'd10:   o = 3'd6;
			4'd11:   o = 3'd2;
			4'd12:   o = 3'd4;
			default: o = 3'd0;
		endcase
		return o;
	endfunction

	function automatic logic [2:0] quarter_of(input logic [MONTH_W-1:0] m);
		logic [2:0] q;
		case (m) inside
			[4'd1:4'd3]: q = 3'd1;
			[4'd4:4'd6]: q = 3'd2;
			[4'd7:4'd9]: q = 3'd3;
			default:     q = 3'd4;
		endcase
		return q;
	endfunction

	// Floor of t / 3 for t up to 29999
	function automatic logic [YEAR_W-1:0] div3(input logic [14:0] t);
		logic [30:0] prod;
		prod = 31'(t) * 31'(RECIP3);
		return prod[30:17];
	endfunction

	// s mod 7 for any 14-bit s
	function automatic logic [2:0] mod7(input logic [13:0] s);
		logic [29:0] prod;
		logic [13:0] rem;
		prod = 30'(s) * 30'(RECIP7W);
		rem  = s - 14'(prod[29:18]) * 14'd7;
		return rem[2:0];
	endfunction

	// Floor of x / 7 for x up to 372
	function automatic logic [WEEK_W-1:0] div7(input logic [DOY_W-1:0] x);
		logic [20:0] prod;
		prod = 21'(x) * 21'(RECIP7N);
		return prod[19:14];
	endfunction

endpackage

### rtl/core/cdu_if.sv
// Channel interfaces: date input, result output and configuration write.
interface cdu_date_if;
	import cdu_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [YEAR_W-1:0]         year;
	logic [MONTH_W-1:0]        month;
	logic [DAY_W-1:0]          day;
	logic signed [DELTA_W-1:0] month_delta;

	modport source (output valid, year, month, day, month_delta, input ready);
	modport sink (input valid, year, month, day, month_delta, output ready);
endinterface

interface cdu_result_if;
	import cdu_pkg::*;
	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  moved_year;
	logic [MONTH_W-1:0] moved_month;
	logic [DAY_W-1:0]   moved_day;
	logic               move_out_of_range;
	logic [DOY_W-1:0]   day_of_year;
	logic [WEEK_W-1:0]  week_number;
	logic [2:0]         quarter;
	logic               leap_year;
	logic [DAY_W-1:0]   month_length;
	logic [2:0]         weekday;

	modport source (output valid, moved_year, moved_month, moved_day, move_out_of_range,
		day_of_year, week_number, quarter, leap_year, month_length, weekday, input ready);
	modport sink (input valid, moved_year, moved_month, moved_day, move_out_of_range,
		day_of_year, week_number, quarter, leap_year, month_length, weekday, output ready);
endinterface

interface cdu_cfg_if;
	logic valid;
	logic ready;
	logic week_mode;

	modport source (output valid, week_mode, input ready);
	modport sink (input valid, week_mode, output ready);
endinterface

### rtl/core/calendar_date_unit.sv
// Calendar date unit top level: month move and date facts, one date per cycle while results are taken.
// Each date passes through the stage registers s1 to s5 in order before its result is presented.
// Throughput: one date per cycle unless the result is stalled; five stage registers with per-stage enables.
// Input ready drops only when all five stages hold dates and the result is not taken.
// Reset clears the stage valid bits and sets week_mode to ISO weeks; data registers are not reset.
module calendar_date_unit (
	input  logic         clk,
	input  logic         arst_n,
	cdu_date_if.sink     date_in,
	cdu_result_if.source result_out,
	cdu_cfg_if.sink      cfg
);
	import cdu_pkg::*;

	logic             week_mode_q;
	pipe_en_t         en;
	norm_t            norm;
	logic [DAY_W-1:0] day_clamped;
	info_t            info;
	move_t            move;

	// Accept configuration writes at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			week_mode_q <= WEEK_ISO;
		else if (cfg.valid)
			week_mode_q <= cfg.week_mode;
	end

	cdu_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (date_in.valid),
		.in_ready  (date_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.en        (en)
	);

	cdu_front u_front (
		.clk         (clk),
		.en          (en),
		.year        (date_in.year),
		.month       (date_in.month),
		.day         (date_in.day),
		.month_delta (date_in.month_delta),
		.norm        (norm)
	);

	cdu_date_info u_info (
		.clk         (clk),
		.en          (en),
		.week_mode   (week_mode_q),
		.norm        (norm),
		.day_clamped (day_clamped),
		.info        (info)
	);

	cdu_month_move u_move (
		.clk         (clk),
		.en          (en),
		.norm        (norm),
		.day_clamped (day_clamped),
		.move        (move)
	);

	// Drive the result payload
	assign result_out.moved_year        = move.moved_year;
	assign result_out.moved_month       = move.moved_month;
	assign result_out.moved_day         = move.moved_day;
	assign result_out.move_out_of_range = move.move_out_of_range;
	assign result_out.day_of_year       = info.day_of_year;
	assign result_out.week_number       = info.week_number;
	assign result_out.quarter           = info.quarter;
	assign result_out.leap_year         = info.leap_year;
	assign result_out.month_length      = info.month_length;
	assign result_out.weekday           = info.weekday;

	// Input back-pressure only comes from a full pipe with a stalled result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!date_in.ready |-> result_out.valid && !result_out.ready)
		else $error("input stalled without a stalled result");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.move_out_of_range |->
		result_out.moved_year == '0 && result_out.moved_month == '0 &&
		result_out.moved_day == '0)
		else $error("out-of-range move with nonzero date");

	a_moved_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.move_out_of_range |->
		result_out.moved_year >= 14'd1 && result_out.moved_year <= YEAR_MAX &&
		result_out.moved_month >= 4'd1 && result_out.moved_month <= MONTH_MAX &&
		result_out.moved_day >= 5'd1 && result_out.moved_day <= result_out.moved_day + 5'd0 &&
		result_out.moved_day <= 5'd31)
		else $error("moved date out of calendar range");

	a_info_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |->
		result_out.weekday >= 3'd1 && result_out.weekday <= 3'd7 &&
		result_out.week_number >= 6'd1 && result_out.week_number <= 6'd53 &&
		result_out.day_of_year >= 9'd1 && result_out.day_of_year <= 9'd366)
		else $error("date facts out of range");
endmodule

### rtl/core/cdu_pipe_ctrl.sv
// Stage valid bits and per-stage load enables for the five-stage pipeline.
module cdu_pipe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output cdu_pkg::pipe_en_t en
);
	import cdu_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// Load a stage when it is empty or its contents move on
	always_comb begin
		en.s5 = !valid_s5 || out_ready;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	// Advance valid bits with their stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	assign in_ready  = en.s1;
	assign out_valid = valid_s5;
endmodule

### rtl/core/cdu_front.sv
// Input register, year/month clamping, century quotients and month total.
module cdu_front (
	input  logic                              clk,
	input  cdu_pkg::pipe_en_t                 en,
	input  logic [cdu_pkg::YEAR_W-1:0]        year,
	input  logic [cdu_pkg::MONTH_W-1:0]       month,
	input  logic [cdu_pkg::DAY_W-1:0]         day,
	input  logic signed [cdu_pkg::DELTA_W-1:0] month_delta,
	output cdu_pkg::norm_t                    norm
);
	import cdu_pkg::*;

	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [DELTA_W-1:0] delta_s1;

	logic [YEAR_W-1:0]  year_c;
	logic [YEAR_W-1:0]  year_p;
	logic [MONTH_W-1:0] month_c;
	logic [TOTAL_W-1:0] year_x;
	logic [TOTAL_W-1:0] total;
	norm_t              norm_s2;

	// Capture the input date on transfer
	always_ff @(posedge clk) begin
		if (en.s1) begin
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
			delta_s1 <= month_delta;
		end
	end

	// Clamp year and month, form the month count year*12 + month-1 + delta
	always_comb begin
		if (year_s1 == '0)
			year_c = 14'd1;
		else if (year_s1 > YEAR_MAX)
			year_c = YEAR_MAX;
		else
			year_c = year_s1;
		if (month_s1 == '0)
			month_c = 4'd1;
		else if (month_s1 > MONTH_MAX)
			month_c = MONTH_MAX;
		else
			month_c = month_s1;
		year_p = year_c - 14'd1;
		year_x = {5'd0, year_c};
		total  = (year_x << 3) + (year_x << 2) + {15'd0, month_c - 4'd1}
			+ {{(TOTAL_W-DELTA_W){delta_s1[DELTA_W-1]}}, delta_s1};
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			norm_s2.year      <= year_c;
			norm_s2.year_prev <= year_p;
			norm_s2.cent      <= div100(year_c);
			norm_s2.cent_prev <= div100(year_p);
			norm_s2.month     <= month_c;
			norm_s2.day       <= day_s1;
			norm_s2.total     <= total;
		end
	end

	assign norm = norm_s2;
endmodule

### rtl/core/cdu_date_info.sv
// Facts about the input date: leap, month length, ordinal day, quarter, weekday and week.
module cdu_date_info (
	input  logic                        clk,
	input  cdu_pkg::pipe_en_t           en,
	input  logic                        week_mode,
	input  cdu_pkg::norm_t              norm,
	output logic [cdu_pkg::DAY_W-1:0]   day_clamped,
	output cdu_pkg::info_t              info
);
	import cdu_pkg::*;

	logic               leap;
	logic               leap_prev;
	logic [DAY_W-1:0]   mlen;
	logic [DAY_W-1:0]   day_c;
	logic [DOY_W-1:0]   doy;
	logic [YEAR_W-1:0]  year_d;
	logic [CENT_W-1:0]  cent_d;
	logic [13:0]        dsum;

	logic               leap_s3, leap_prev_s3;
	logic [DAY_W-1:0]   mlen_s3, day_s3;
	logic [DOY_W-1:0]   doy_s3;
	logic [13:0]        dsum_s3;
	logic [2:0]         quarter_s3;

	logic               leap_s4, leap_prev_s4;
	logic [DAY_W-1:0]   mlen_s4;
	logic [DOY_W-1:0]   doy_s4;
	logic [2:0]         dow_s4;
	logic [2:0]         quarter_s4;

	logic [2:0]         dow_mon;
	logic [9:0]         thu_doy;
	logic [9:0]         year_len;
	logic [9:0]         thu_adj;
	logic [9:0]         thu_m1;
	logic [WEEK_W-1:0]  week_iso;
	logic [WEEK_W-1:0]  week_simple;
	info_t              info_s5;

	// Leap flags, month length, day clamp, ordinal day and weekday sum
	always_comb begin
		leap      = is_leap(norm.year, norm.cent);
		leap_prev = is_leap(norm.year_prev, norm.cent_prev);
		mlen      = month_len(norm.month, leap);
		if (norm.day == '0)
			day_c = 5'd1;
		else if (norm.day > mlen)
			day_c = mlen;
		else
			day_c = norm.day;
		doy = days_before(norm.month) + {8'd0, leap && (norm.month > 4'd2)} + {4'd0, day_c};
		// January and February count against the previous year
		year_d = (norm.month < 4'd3) ? norm.year_prev : norm.year;
		cent_d = (norm.month < 4'd3) ? norm.cent_prev : norm.cent;
		dsum   = year_d + (year_d >> 2) - 14'(cent_d) + 14'(cent_d >> 2)
			+ 14'(dow_offset(norm.month)) + 14'(day_c);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			leap_s3      <= leap;
			leap_prev_s3 <= leap_prev;
			mlen_s3      <= mlen;
			day_s3       <= day_c;
			doy_s3       <= doy;
			dsum_s3      <= dsum;
			quarter_s3   <= quarter_of(norm.month);
		end
	end

	// Reduce the weekday sum mod 7
	always_ff @(posedge clk) begin
		if (en.s4) begin
			leap_s4      <= leap_s3;
			leap_prev_s4 <= leap_prev_s3;
			mlen_s4      <= mlen_s3;
			doy_s4       <= doy_s3;
			dow_s4       <= mod7(dsum_s3);
			quarter_s4   <= quarter_s3;
		end
	end

	// Locate the Thursday of the Monday-based week, wrap into its own year, form both week numbers
	always_comb begin
		dow_mon  = (dow_s4 == 3'd0) ? 3'd6 : dow_s4 - 3'd1;
		thu_doy  = {1'b0, doy_s4} + 10'd3 - {7'd0, dow_mon};
		year_len = leap_s4 ? 10'd366 : 10'd365;
		if ($signed(thu_doy) < 10'sd1)
			thu_adj = thu_doy + (leap_prev_s4 ? 10'd366 : 10'd365);
		else if ($signed(thu_doy) > $signed(year_len))
			thu_adj = thu_doy - year_len;
		else
			thu_adj = thu_doy;
		thu_m1      = thu_adj - 10'd1;
		week_iso    = div7(thu_m1[DOY_W-1:0]) + 6'd1;
		week_simple = div7(doy_s4 + 9'd6);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			info_s5.day_of_year  <= doy_s4;
			info_s5.week_number  <= (week_mode == WEEK_SIMPLE) ? week_simple : week_iso;
			info_s5.quarter      <= quarter_s4;
			info_s5.leap_year    <= leap_s4;
			info_s5.month_length <= mlen_s4;
			info_s5.weekday      <= dow_s4 + 3'd1;
		end
	end

	assign day_clamped = day_s3;
	assign info        = info_s5;
endmodule

### rtl/core/cdu_month_move.sv
// Month move: split the month count into year and month, clamp the day, flag out-of-range moves.
module cdu_month_move (
	input  logic                      clk,
	input  cdu_pkg::pipe_en_t         en,
	input  cdu_pkg::norm_t            norm,
	input  logic [cdu_pkg::DAY_W-1:0] day_clamped,
	output cdu_pkg::move_t            move
);
	import cdu_pkg::*;

	logic               oor;
	logic               oor_s3;
	logic [YEAR_W-1:0]  ny_s3;
	logic [16:0]        tot_s3;

	logic [16:0]        month0;
	logic [MONTH_W-1:0] nm;
	logic               nleap;
	logic [DAY_W-1:0]   nlen;
	move_t              move_c;
	move_t              move_s4;
	move_t              move_s5;

	// Range check and divide the count by 12 as (count / 4) / 3
	assign oor = ($signed(norm.total) < MOVE_MIN) || ($signed(norm.total) >= MOVE_LIM);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			oor_s3 <= oor;
			ny_s3  <= div3(norm.total[16:2]);
			tot_s3 <= norm.total[16:0];
		end
	end

	// Form the target month, its length and the clamped day
	always_comb begin
		month0 = tot_s3 - 17'(ny_s3) * 17'd12;
		nm     = month0[MONTH_W-1:0] + 4'd1;
		nleap  = is_leap(ny_s3, div100(ny_s3));
		nlen   = month_len(nm, nleap);
		if (oor_s3) begin
			move_c.moved_year  = '0;
			move_c.moved_month = '0;
			move_c.moved_day   = '0;
		end else begin
			move_c.moved_year  = ny_s3;
			move_c.moved_month = nm;
			move_c.moved_day   = (day_clamped > nlen) ? nlen : day_clamped;
		end
		move_c.move_out_of_range = oor_s3;
	end

	always_ff @(posedge clk) begin
		if (en.s4) move_s4 <= move_c;
	end

	// Hold alongside the week stage of the date path
	always_ff @(posedge clk) begin
		if (en.s5) move_s5 <= move_s4;
	end

	assign move = move_s5;
endmodule

### tb/calendar_date_unit_tb.sv
// Self-checking testbench for the calendar date unit: directed and random dates against a predictor.
module calendar_date_unit_tb;
	import cdu_pkg::*;

	// Every field of one result transfer
	typedef struct {
		logic [YEAR_W-1:0]  moved_year;
		logic [MONTH_W-1:0] moved_month;
		logic [DAY_W-1:0]   moved_day;
		logic               move_out_of_range;
		logic [DOY_W-1:0]   day_of_year;
		logic [WEEK_W-1:0]  week_number;
		logic [2:0]         quarter;
		logic               leap_year;
		logic [DAY_W-1:0]   month_length;
		logic [2:0]         weekday;
	} date_facts_t;

	typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_BEAT, DRAIN_SLOW} drain_pattern_t;

	// Predicts date facts for each accepted date and checks them against the results
	class date_tracker;
		logic        week_mode;
		int          errors;
		date_facts_t expected_facts[$];
		int          cum_days[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
		int          dow_shift[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

		function new();
			week_mode = WEEK_ISO;
			errors = 0;
		endfunction

		function bit leap_of(int y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function int days_in_month(int m, bit lp);
			if (m == 2)
				return lp ? 29 : 28;
			if (m == 4 || m == 6 || m == 9 || m == 11)
				return 30;
			return 31;
		endfunction

		// 0 Sunday .. 6 Saturday
		function int weekday0(int y, int m, int d);
			int yy;
			yy = (m < 3) ? y - 1 : y;
			return (yy + yy / 4 - yy / 100 + yy / 400 + dow_shift[m-1] + d) % 7;
		endfunction

		function date_facts_t calendar_facts(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
				logic [DAY_W-1:0] dy, logic signed [DELTA_W-1:0] delta);
			date_facts_t f;
			int y, m, d, mlen, total, ny, nm, nlen, doy, dow0, tdoy, ylen, wk;
			bit lp;
			// clamp the input date into range
			y = yr;
			if (y < 1) y = 1;
			if (y > 9999) y = 9999;
			m = mo;
			if (m < 1) m = 1;
			if (m > 12) m = 12;
			lp = leap_of(y);
			mlen = days_in_month(m, lp);
			d = dy;
			if (d < 1) d = 1;
			if (d > mlen) d = mlen;

			// month move with day clamped to the target month
			total = y * 12 + m - 1 + int'(delta);
			f.moved_year = '0;
			f.moved_month = '0;
			f.moved_day = '0;
			f.move_out_of_range = 1'b0;
			if (total < 12 || total >= 120000) begin
				f.move_out_of_range = 1'b1;
			end else begin
				ny = total / 12;
				nm = total % 12 + 1;
				nlen = days_in_month(nm, leap_of(ny));
				f.moved_year = YEAR_W'(ny);
				f.moved_month = MONTH_W'(nm);
				f.moved_day = DAY_W'(d > nlen ? nlen : d);
			end

			doy = cum_days[m-1] + ((lp && m > 2) ? 1 : 0) + d;
			dow0 = weekday0(y, m, d);

			if (week_mode == WEEK_SIMPLE) begin
				wk = (doy + 6) / 7;
			end else begin
				// count the week by its Thursday, which may sit in the adjacent year
				tdoy = doy + 3 - ((dow0 + 6) % 7);
				ylen = lp ? 366 : 365;
				if (tdoy < 1)
					tdoy += leap_of(y - 1) ? 366 : 365;
				else if (tdoy > ylen)
					tdoy -= ylen;
				wk = (tdoy - 1) / 7 + 1;
			end

			f.day_of_year = DOY_W'(doy);
			f.week_number = WEEK_W'(wk);
			f.quarter = 3'((m + 2) / 3);
			f.leap_year = lp;
			f.month_length = DAY_W'(mlen);
			f.weekday = 3'(dow0 + 1);
			return f;
		endfunction

		function int pending();
			return expected_facts.size();
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task note_date(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo, logic [DAY_W-1:0] dy,
				logic signed [DELTA_W-1:0] delta);
			expected_facts.push_back(calendar_facts(yr, mo, dy, delta));
		endtask

		task cmp_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		task check_result(date_facts_t got);
			date_facts_t want;
			if (expected_facts.size() == 0) begin
				report("result transfer with no date outstanding");
				return;
			end
			want = expected_facts.pop_front();
			cmp_field("moved_year", 16'(got.moved_year), 16'(want.moved_year));
			cmp_field("moved_month", 16'(got.moved_month), 16'(want.moved_month));
			cmp_field("moved_day", 16'(got.moved_day), 16'(want.moved_day));
			cmp_field("move_out_of_range", 16'(got.move_out_of_range),
				16'(want.move_out_of_range));
			cmp_field("day_of_year", 16'(got.day_of_year), 16'(want.day_of_year));
			cmp_field("week_number", 16'(got.week_number), 16'(want.week_number));
			cmp_field("quarter", 16'(got.quarter), 16'(want.quarter));
			cmp_field("leap_year", 16'(got.leap_year), 16'(want.leap_year));
			cmp_field("month_length", 16'(got.month_length), 16'(want.month_length));
			cmp_field("weekday", 16'(got.weekday), 16'(want.weekday));
		endtask
	endclass

	logic clk;
	logic arst_n;

	cdu_date_if   date_in();
	cdu_result_if result_out();
	cdu_cfg_if    cfg();

	calendar_date_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.date_in    (date_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	date_tracker    tracker = new();
	date_facts_t    seen_facts;
	int             burst_left;
	int             drain_left = 0;
	drain_pattern_t drain_mode = DRAIN_FREE;

	always #5 clk = ~clk;

	// Track register writes, check results, then note accepted dates
	always @(posedge clk) begin
		if (cfg.valid && cfg.ready)
			tracker.week_mode = cfg.week_mode;
		if (result_out.valid && result_out.ready) begin
			seen_facts.moved_year = result_out.moved_year;
			seen_facts.moved_month = result_out.moved_month;
			seen_facts.moved_day = result_out.moved_day;
			seen_facts.move_out_of_range = result_out.move_out_of_range;
			seen_facts.day_of_year = result_out.day_of_year;
			seen_facts.week_number = result_out.week_number;
			seen_facts.quarter = result_out.quarter;
			seen_facts.leap_year = result_out.leap_year;
			seen_facts.month_length = result_out.month_length;
			seen_facts.weekday = result_out.weekday;
			tracker.check_result(seen_facts);
		end
		if (date_in.valid && date_in.ready)
			tracker.note_date(date_in.year, date_in.month, date_in.day, date_in.month_delta);
	end

	// Stall the result side on a random pattern that is redrawn whenever its countdown runs out
	always @(posedge clk) begin
		if (drain_left == 0) begin
			drain_mode <= drain_pattern_t'($urandom_range(0, 3));
			drain_left <= $urandom_range(40, 200);
		end else begin
			drain_left <= drain_left - 1;
		end
		case (drain_mode)
			DRAIN_FREE: result_out.ready <= 1'b1;
			DRAIN_COIN: result_out.ready <= ($urandom_range(0, 1) == 0);
			DRAIN_BEAT: result_out.ready <= (drain_left % 3 != 0);
			default:    result_out.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Offer one date and hold it until the transfer; close a burst with a gap
	task automatic send_date(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
			logic [DAY_W-1:0] dy, logic [DELTA_W-1:0] delta);
		date_in.valid <= 1'b1;
		date_in.year <= yr;
		date_in.month <= mo;
		date_in.day <= dy;
		date_in.month_delta <= delta;
		do @(posedge clk); while (!date_in.ready);
		if (burst_left == 0) begin
			date_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 60);
		end else begin
			burst_left--;
		end
	endtask

	// Hold off input until every outstanding result has come back
	task automatic settle();
		date_in.valid <= 1'b0;
		// let the monitor note a date taken at the last edge
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_week_mode(logic mode);
		cfg.valid <= 1'b1;
		cfg.week_mode <= mode;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Mostly well-formed dates near the interesting edges, some raw bit patterns
	task automatic send_random();
		int y, m, d, mlen;
		logic [DELTA_W-1:0] delta;
		if ($urandom_range(0, 99) < 15) begin
			send_date(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
				DELTA_W'($urandom));
			return;
		end
		case ($urandom_range(0, 5))
			0:       y = $urandom_range(1, 3);
			1:       y = $urandom_range(9997, 9999);
			2:       y = $urandom_range(1, 99) * 100;
			default: y = $urandom_range(1, 9999);
		endcase
		m = $urandom_range(1, 12);
		mlen = tracker.days_in_month(m, tracker.leap_of(y));
		case ($urandom_range(0, 3))
			0:       d = 1;
			1:       d = mlen;
			default: d = $urandom_range(1, mlen);
		endcase
		case ($urandom_range(0, 3))
			0:       delta = DELTA_W'($urandom_range(0, 80) - 40);
			1:       delta = DELTA_W'($urandom_range(0, 2400) - 1200);
			2:       delta = '0;
			default: delta = DELTA_W'($urandom);
		endcase
		send_date(YEAR_W'(y), MONTH_W'(m), DAY_W'(d), delta);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		date_in.valid = 1'b0;
		date_in.year = '0;
		date_in.month = '0;
		date_in.day = '0;
		date_in.month_delta = '0;
		result_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.week_mode = WEEK_ISO;
		burst_left = $urandom_range(1, 40);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ISO weeks: year ends, clamped moves, century leap rules, range limits
		load_week_mode(WEEK_ISO);
		send_date(14'd2020, 4'd12, 5'd31, 16'd0);
		send_date(14'd2021, 4'd1, 5'd1, 16'd0);
		send_date(14'd2019, 4'd12, 5'd30, 16'd0);
		send_date(14'd2024, 4'd1, 5'd31, 16'd1);
		send_date(14'd2023, 4'd3, 5'd31, -16'sd1);
		send_date(14'd1900, 4'd2, 5'd28, 16'd12);
		send_date(14'd2000, 4'd2, 5'd29, 16'd12);
		send_date(14'd1, 4'd1, 5'd1, 16'd0);
		send_date(14'd1, 4'd1, 5'd1, -16'sd1);
		send_date(14'd9999, 4'd12, 5'd31, 16'd0);
		send_date(14'd9999, 4'd12, 5'd31, 16'd1);
		send_date(14'd5000, 4'd6, 5'd15, 16'h7FFF);
		send_date(14'd5000, 4'd6, 5'd15, 16'h8000);
		send_date(14'd0, 4'd0, 5'd0, 16'd0);
		send_date(14'h3FFF, 4'hF, 5'h1F, 16'h7FFF);
		send_date(14'd2021, 4'd4, 5'd31, 16'd0);
		send_date(14'd2021, 4'd2, 5'd30, 16'd0);

		// simple weeks around the week boundaries
		settle();
		load_week_mode(WEEK_SIMPLE);
		send_date(14'd2020, 4'd12, 5'd31, 16'd0);
		send_date(14'd2021, 4'd1, 5'd7, 16'd0);
		send_date(14'd2021, 4'd1, 5'd8, 16'd0);
		send_date(14'd2015, 4'd12, 5'd31, 16'd0);

		// random dates, alternating week numbering between phases
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			load_week_mode((ph % 2 == 1) ? WEEK_SIMPLE : WEEK_ISO);
			repeat (250) send_random();
		end

		settle();
		if (tracker.pending() != 0)
			tracker.report("results still outstanding at end of run");
		if (tracker.errors == 0) begin
			$display("calendar_date_unit_tb: PASS");
		end else begin
			$display("calendar_date_unit_tb: FAIL");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2000000;
		$display("calendar_date_unit_tb: FAIL");
		$finish;
	end

endmodule
